/* sv/slt_pkg.sv */
// ----------------------------------------------------------------------------
// Script lexer package
// Shared record types, token codes and scanner modes.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int MaxTextBytes     = 1023;
  localparam int KeywordStoreBytes = 9;
  localparam int MaxRecords       = 6;
  localparam int CntW             = $clog2(MaxRecords + 1);

  typedef enum logic [5:0] {
    T_EOF, T_NEWLINE, T_KEYWORD, T_IDENT, T_HAS, T_NOT, T_AND, T_OR,
    T_PROPERTY, T_STRING, T_NUMBER, T_LBRACE, T_RBRACE, T_EQ, T_BLOCK,
    T_ASSIGN, T_LPAREN, T_RPAREN, T_LBRACKET, T_RBRACKET, T_ATTR, T_COMMA,
    T_COLON, T_DQUEST, T_QUEST, T_ADD, T_ARROW, T_MINUS, T_POW, T_MUL,
    T_DIV, T_MOD, T_LE, T_LT, T_GE, T_GT, T_NE, T_UNDEF
  } token_e;

  typedef enum logic [4:0] {
    M_IDLE, M_COMMENT, M_IDENT, M_PROP, M_DEC, M_ZERO, M_HEX, M_BIN, M_OCT,
    M_STR, M_STR_ESC, M_ESC_OCT, M_ESC_HEX, M_ESC_U4, M_ESC_U8,
    M_OP_EQ, M_OP_QUEST, M_OP_MINUS, M_OP_STAR, M_OP_LT, M_OP_GT, M_OP_BANG
  } mode_e;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] text;
    token_e     ttype;
    logic       ovf;
  } rec_t;

  typedef struct packed {
    rec_t [MaxRecords-1:0] recs;
    logic [CntW-1:0]       cnt;
  } batch_t;

endpackage

/* sv/slt_if.sv */
// ----------------------------------------------------------------------------
// Script lexer channels
// Source byte channel and token record channel.
// ----------------------------------------------------------------------------
interface slt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface slt_out_if;
  logic       valid;
  logic       ready;
  logic       record_kind;
  logic [7:0] text_byte;
  logic [5:0] token_type;
  logic       text_overflow;
  logic       last;
  modport source (output valid, record_kind, text_byte, token_type, text_overflow, last,
                  input ready);
  modport sink (input valid, record_kind, text_byte, token_type, text_overflow, last,
                output ready);
endinterface

/* sv/slt_core.sv */
// ----------------------------------------------------------------------------
// Script lexer scanner core
// Per-word scanner state update and result batch generation.
// ----------------------------------------------------------------------------
module slt_core #(
  parameter int MAX_TEXT_BYTES      = slt_pkg::MaxTextBytes,
  parameter int KEYWORD_STORE_BYTES = slt_pkg::KeywordStoreBytes
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [7:0]      byte_i,
  input  logic            eoi_i,
  input  logic            can_load_i,
  output logic            ready_o,
  output logic            load_o,
  output slt_pkg::batch_t batch_o
);
  import slt_pkg::*;

  localparam int LW = $clog2(MAX_TEXT_BYTES + 2);
  localparam int KW = $clog2(KEYWORD_STORE_BYTES);
  localparam logic [LW-1:0] MaxLen = LW'(MAX_TEXT_BYTES);

  typedef struct packed {
    mode_e                 mode;
    logic                  quote;
    logic [31:0]           esc;
    logic [3:0]            ecnt;
    logic [LW-1:0]         len;
    rec_t [MaxRecords-1:0] recs;
    logic [CntW-1:0]       n;
    logic                  done;
    logic                  wr;
    logic [KW-1:0]         widx;
    logic [7:0]            wbyte;
  } work_t;

  mode_e         mode_q;
  logic          quote_q;
  logic [31:0]   esc_q;
  logic [3:0]    ecnt_q;
  logic [LW-1:0] len_q;
  logic [7:0]    store_q [KEYWORD_STORE_BYTES];
  work_t         w_d;
  logic          acc;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_word(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || b == "_";
  endfunction

  function automatic logic is_odig(logic [7:0] b);
    return b >= "0" && b <= "7";
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] b);
    logic [7:0] v;
    if (is_digit(b)) v = b - 8'h30;
    else if (b >= "a" && b <= "f") v = b - 8'h57;
    else v = b - 8'h37;
    return v[3:0];
  endfunction

  function automatic logic word_is(logic [LW-1:0] len, logic [71:0] w, int n);
    logic m;
    m = (len == LW'(n)) && (n <= KEYWORD_STORE_BYTES);
    for (int i = 0; i < 9; i++) begin
      if (i < n && i < KEYWORD_STORE_BYTES) begin
        if (store_q[i] != w[8*(n-1-i) +: 8]) m = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic work_t put_text(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    if (w.len < MaxLen) begin
      r.recs[w.n] = '{kind: KIND_TEXT, text: b, ttype: T_EOF, ovf: 1'b0};
      r.n = w.n + 1'b1;
      r.len = w.len + 1'b1;
    end else begin
      r.len = MaxLen + 1'b1;
    end
    return r;
  endfunction

  function automatic work_t put_end(work_t w, token_e t);
    work_t r;
    r = w;
    r.recs[w.n] = '{kind: KIND_END, text: 8'h00, ttype: t, ovf: (w.len > MaxLen)};
    r.n = w.n + 1'b1;
    r.len = '0;
    r.mode = M_IDLE;
    return r;
  endfunction

  function automatic work_t end_word(work_t w);
    token_e t;
    t = T_IDENT;
    if (word_is(w.len, 72'("if"), 2) || word_is(w.len, 72'("elif"), 4) ||
        word_is(w.len, 72'("else"), 4) || word_is(w.len, 72'("while"), 5) ||
        word_is(w.len, 72'("for"), 3) || word_is(w.len, 72'("in"), 2) ||
        word_is(w.len, 72'("break"), 5) || word_is(w.len, 72'("continue"), 8) ||
        word_is(w.len, 72'("return"), 6) || word_is(w.len, 72'("implement"), 9))
      t = T_KEYWORD;
    if (word_is(w.len, 72'("has"), 3)) t = T_HAS;
    else if (word_is(w.len, 72'("not"), 3)) t = T_NOT;
    else if (word_is(w.len, 72'("and"), 3)) t = T_AND;
    else if (word_is(w.len, 72'("or"), 2)) t = T_OR;
    return put_end(w, t);
  endfunction

  function automatic work_t put_utf8(work_t w, logic [31:0] c);
    work_t r;
    r = w;
    if (c < 32'h80) begin
      r = put_text(r, c[7:0]);
    end else if (c < 32'h800) begin
      r = put_text(r, 8'hC0 | c[13:6]);
      r = put_text(r, 8'h80 | {2'b00, c[5:0]});
    end else if (c < 32'h10000) begin
      r = put_text(r, 8'hE0 | c[19:12]);
      r = put_text(r, 8'h80 | {2'b00, c[11:6]});
      r = put_text(r, 8'h80 | {2'b00, c[5:0]});
    end else begin
      r = put_text(r, 8'hF0 | c[25:18]);
      r = put_text(r, 8'h80 | {2'b00, c[17:12]});
      r = put_text(r, 8'h80 | {2'b00, c[11:6]});
      r = put_text(r, 8'h80 | {2'b00, c[5:0]});
    end
    return r;
  endfunction

  function automatic work_t single(work_t w, logic [7:0] b, token_e t);
    return put_end(put_text(w, b), t);
  endfunction

  function automatic work_t pend(work_t w, logic [7:0] b, mode_e m);
    work_t r;
    r = put_text(w, b);
    r.mode = m;
    return r;
  endfunction

  function automatic work_t op_pair(work_t w, logic [7:0] b, logic [7:0] want,
                                    token_e t2, token_e t1);
    work_t r;
    if (b == want) begin
      r = single(w, b, t2);
      r.done = 1'b1;
    end else begin
      r = put_end(w, t1);
      r.done = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t start(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    r.mode = M_IDLE;
    case (b)
      " ", 8'h09: r = w;
      "#": r.mode = M_COMMENT;
      ";", 8'h0A, 8'h0D: r = put_end(r, T_NEWLINE);
      "$": r.mode = M_PROP;
      8'h22, 8'h27: begin
        r.quote = (b == 8'h27);
        r.mode = M_STR;
      end
      "0": r = pend(r, b, M_ZERO);
      "{": r = single(r, b, T_LBRACE);
      "}": r = single(r, b, T_RBRACE);
      "(": r = single(r, b, T_LPAREN);
      ")": r = single(r, b, T_RPAREN);
      "[": r = single(r, b, T_LBRACKET);
      "]": r = single(r, b, T_RBRACKET);
      8'h5C: r = single(r, b, T_ATTR);
      ",": r = single(r, b, T_COMMA);
      ":": r = single(r, b, T_COLON);
      "+": r = single(r, b, T_ADD);
      "/": r = single(r, b, T_DIV);
      "%": r = single(r, b, T_MOD);
      "=": r = pend(r, b, M_OP_EQ);
      "?": r = pend(r, b, M_OP_QUEST);
      "-": r = pend(r, b, M_OP_MINUS);
      "*": r = pend(r, b, M_OP_STAR);
      "<": r = pend(r, b, M_OP_LT);
      ">": r = pend(r, b, M_OP_GT);
      "!": r = pend(r, b, M_OP_BANG);
      default: begin
        if (is_alpha(b) || b == "_") begin
          r.wr = 1'b1;
          r.widx = '0;
          r.wbyte = b;
          r = pend(r, b, M_IDENT);
        end else if (is_digit(b)) begin
          r = pend(r, b, M_DEC);
        end else begin
          r = single(r, b, T_UNDEF);
        end
      end
    endcase
    r.done = 1'b1;
    return r;
  endfunction

  function automatic work_t str_escape(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    r.mode = M_STR;
    r.esc = '0;
    r.ecnt = '0;
    case (b)
      "n": r = put_text(r, 8'h0A);
      "r": r = put_text(r, 8'h0D);
      "t": r = put_text(r, 8'h09);
      "v": r = put_text(r, 8'h0B);
      "f": r = put_text(r, 8'h0C);
      "a": r = put_text(r, 8'h07);
      "x": r.mode = M_ESC_HEX;
      "u": r.mode = M_ESC_U4;
      "U": r.mode = M_ESC_U8;
      default: begin
        if (is_odig(b)) begin
          r.esc = {29'd0, b[2:0]};
          r.ecnt = 4'd1;
          r.mode = M_ESC_OCT;
        end else begin
          r = put_text(r, b);
        end
      end
    endcase
    return r;
  endfunction

  function automatic work_t scan(work_t w, logic [7:0] b);
    work_t r;
    r = w;
    r.done = 1'b1;
    case (w.mode)
      M_COMMENT: begin
        if (b == 8'h0A) begin
          r.mode = M_IDLE;
          r.done = 1'b0;
        end
      end
      M_IDENT: begin
        if (is_word(b)) begin
          if (w.len < LW'(KEYWORD_STORE_BYTES)) begin
            r.wr = 1'b1;
            r.widx = w.len[KW-1:0];
            r.wbyte = b;
          end
          r = put_text(r, b);
        end else begin
          r = end_word(r);
          r.done = 1'b0;
        end
      end
      M_PROP: begin
        if (is_word(b)) r = put_text(r, b);
        else begin
          r = put_end(r, T_PROPERTY);
          r.done = 1'b0;
        end
      end
      M_DEC, M_HEX, M_BIN, M_OCT: begin
        if ((w.mode == M_DEC && is_digit(b)) || (w.mode == M_HEX && is_hex(b)) ||
            (w.mode == M_BIN && (b == "0" || b == "1")) ||
            (w.mode == M_OCT && is_odig(b))) begin
          r = put_text(r, b);
        end else begin
          r = put_end(r, T_NUMBER);
          r.done = 1'b0;
        end
      end
      M_ZERO: begin
        if (b == "x" || b == "X") r = pend(r, "x", M_HEX);
        else if (b == "b" || b == "B") r = pend(r, "b", M_BIN);
        else if (b == "o" || b == "O") r = pend(r, "o", M_OCT);
        else if (is_odig(b)) r = pend(r, b, M_OCT);
        else begin
          r = put_end(r, T_NUMBER);
          r.done = 1'b0;
        end
      end
      M_STR: begin
        if (b == (w.quote ? 8'h27 : 8'h22)) r = put_end(r, T_STRING);
        else if (b == 8'h5C) r.mode = M_STR_ESC;
        else r = put_text(r, b);
      end
      M_STR_ESC: r = str_escape(r, b);
      M_ESC_OCT: begin
        if (is_odig(b)) begin
          r.esc = {w.esc[28:0], b[2:0]};
          r.ecnt = w.ecnt + 1'b1;
          if (r.ecnt >= 4'd3) begin
            r = put_text(r, r.esc[7:0]);
            r.mode = M_STR;
          end
        end else begin
          r = put_text(r, w.esc[7:0]);
          r.mode = M_STR;
          r.done = 1'b0;
        end
      end
      M_ESC_HEX: begin
        if (is_hex(b)) r.esc = {w.esc[27:0], hex_val(b)};
        else begin
          r = put_text(r, w.esc[7:0]);
          r.mode = M_STR;
          r.done = 1'b0;
        end
      end
      M_ESC_U4, M_ESC_U8: begin
        if (is_hex(b)) begin
          r.esc = {w.esc[27:0], hex_val(b)};
          r.ecnt = w.ecnt + 1'b1;
          if (r.ecnt >= ((w.mode == M_ESC_U4) ? 4'd4 : 4'd8)) begin
            r = put_utf8(r, r.esc);
            r.mode = M_STR;
          end
        end else begin
          r = put_utf8(r, w.esc);
          r.mode = M_STR;
          r.done = 1'b0;
        end
      end
      M_OP_EQ: begin
        if (b == ">") r = single(r, b, T_BLOCK);
        else r = op_pair(r, b, "=", T_EQ, T_ASSIGN);
      end
      M_OP_QUEST: r = op_pair(r, b, "?", T_DQUEST, T_QUEST);
      M_OP_MINUS: r = op_pair(r, b, ">", T_ARROW, T_MINUS);
      M_OP_STAR:  r = op_pair(r, b, "*", T_POW, T_MUL);
      M_OP_LT:    r = op_pair(r, b, "=", T_LE, T_LT);
      M_OP_GT:    r = op_pair(r, b, "=", T_GE, T_GT);
      M_OP_BANG:  r = op_pair(r, b, "=", T_NE, T_UNDEF);
      default:    r = start(r, b);
    endcase
    return r;
  endfunction

  function automatic work_t flush(work_t w);
    work_t r;
    r = w;
    case (w.mode)
      M_IDENT: r = end_word(r);
      M_PROP: r = put_end(r, T_PROPERTY);
      M_DEC, M_ZERO, M_HEX, M_BIN, M_OCT: r = put_end(r, T_NUMBER);
      M_STR, M_STR_ESC, M_ESC_OCT, M_ESC_HEX, M_ESC_U4, M_ESC_U8:
        r = put_end(r, T_UNDEF);
      M_OP_EQ: r = put_end(r, T_ASSIGN);
      M_OP_QUEST: r = put_end(r, T_QUEST);
      M_OP_MINUS: r = put_end(r, T_MINUS);
      M_OP_STAR: r = put_end(r, T_MUL);
      M_OP_LT: r = put_end(r, T_LT);
      M_OP_GT: r = put_end(r, T_GT);
      M_OP_BANG: r = put_end(r, T_UNDEF);
      default: r = w;
    endcase
    r.len = '0;
    r = put_end(r, T_EOF);
    r.esc = '0;
    r.ecnt = '0;
    return r;
  endfunction

  always_comb begin
    work_t w;
    w = '0;
    w.mode = mode_q;
    w.quote = quote_q;
    w.esc = esc_q;
    w.ecnt = ecnt_q;
    w.len = len_q;
    if (eoi_i || byte_i == 8'h00) begin
      w = flush(w);
    end else begin
      w = scan(w, byte_i);
      if (!w.done) w = scan(w, byte_i);
    end
    w_d = w;
  end

  assign ready_o = can_load_i;
  assign acc     = valid_i && can_load_i;
  assign load_o  = acc && (w_d.n != '0);
  assign batch_o = '{recs: w_d.recs, cnt: w_d.n};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      quote_q <= 1'b0;
      esc_q   <= '0;
      ecnt_q  <= '0;
      len_q   <= '0;
    end else if (acc) begin
      mode_q  <= w_d.mode;
      quote_q <= w_d.quote;
      esc_q   <= w_d.esc;
      ecnt_q  <= w_d.ecnt;
      len_q   <= w_d.len;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && w_d.wr) store_q[w_d.widx] <= w_d.wbyte;
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= MaxLen + 1'b1) else $error("text length counter out of range");
  a_batch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> w_d.n <= CntW'(MaxRecords)) else $error("batch exceeds record limit");
  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && eoi_i) |=> mode_q == M_IDLE && len_q == '0)
    else $error("scanner not idle after end of input");

endmodule

/* sv/slt_obuf.sv */
// ----------------------------------------------------------------------------
// Script lexer output buffer
// Holds one result batch and drains it one record per handshake.
// ----------------------------------------------------------------------------
module slt_obuf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  slt_pkg::batch_t batch_i,
  output logic            can_load_o,
  output logic            valid_o,
  input  logic            ready_i,
  output slt_pkg::rec_t   rec_o,
  output logic            last_o
);
  import slt_pkg::*;

  rec_t [MaxRecords-1:0] recs_q, recs_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  pop;

  assign valid_o    = cnt_q != '0;
  assign pop        = valid_o && ready_i;
  assign can_load_o = (cnt_q == '0) || (cnt_q == CntW'(1) && ready_i);
  assign rec_o      = recs_q[0];
  assign last_o     = cnt_q == CntW'(1);

  always_comb begin
    recs_d = recs_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      recs_d = batch_i.recs;
      cnt_d  = batch_i.cnt;
    end else if (pop) begin
      for (int i = 0; i < MaxRecords - 1; i++) recs_d[i] = recs_q[i+1];
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    recs_q <= recs_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRecords)) else $error("buffer count out of range");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (cnt_q == '0) || (cnt_q == CntW'(1) && ready_i))
    else $error("batch loaded over undelivered records");
  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> cnt_q != '0) else $error("loaded batch is empty");

endmodule

/* sv/script_lexer_tokenizer.sv */
// ----------------------------------------------------------------------------
// Script lexer tokenizer
// Streams source bytes and emits token text bytes and token end records.
// ----------------------------------------------------------------------------
// The first record of a word is registered in the result buffer and appears in the cycle after the word is accepted.
// One source word per cycle while each word yields at most one record and the
// record channel is ready; a word yielding several records stalls the input
// until the single record output port has drained the buffer to its last record.
// Reset: asynchronous, clears scanner state and empties the result buffer.
module script_lexer_tokenizer #(
  parameter int MAX_TEXT_BYTES      = slt_pkg::MaxTextBytes,
  parameter int KEYWORD_STORE_BYTES = slt_pkg::KeywordStoreBytes
) (
  input  logic clk_i,
  input  logic rst_ni,
  slt_in_if.sink    in_i,
  slt_out_if.source out_o
);
  import slt_pkg::*;

  batch_t batch;
  rec_t   rec;
  logic   load;
  logic   can_load;

  slt_core #(
    .MAX_TEXT_BYTES      (MAX_TEXT_BYTES),
    .KEYWORD_STORE_BYTES (KEYWORD_STORE_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_i.valid),
    .byte_i     (in_i.in_byte),
    .eoi_i      (in_i.end_of_input),
    .can_load_i (can_load),
    .ready_o    (in_i.ready),
    .load_o     (load),
    .batch_o    (batch)
  );

  slt_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .batch_i    (batch),
    .can_load_o (can_load),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .rec_o      (rec),
    .last_o     (out_o.last)
  );

  assign out_o.record_kind   = rec.kind;
  assign out_o.text_byte     = rec.text;
  assign out_o.token_type    = rec.ttype;
  assign out_o.text_overflow = rec.ovf;

endmodule

/* bench/slt_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Script lexer record checker
// Watches the source and record channels, predicts the token records for
// every accepted source word and compares each accepted record with them.
// ----------------------------------------------------------------------------
module slt_checker (
  input  logic     clk_i,
  input  logic     rst_ni,
  slt_in_if        src_i,
  slt_out_if       rec_i,
  output int       fail_cnt_o,
  output int       pending_o
);
  import slt_pkg::*;

  typedef struct {
    logic       kind;
    logic [7:0] text;
    logic [5:0] ttype;
    logic       ovf;
    logic       last;
  } tok_rec_t;

  tok_rec_t   tok_q[$];
  mode_e      scan;
  logic       quote_single;
  logic [31:0] esc_val;
  int         esc_cnt;
  logic [7:0] kw_store[KeywordStoreBytes];
  int         text_len;

  assign pending_o = tok_q.size();

  function automatic void put_rec(logic k, logic [7:0] b, logic [5:0] t, logic o);
    tok_rec_t r;
    r.kind = k; r.text = b; r.ttype = t; r.ovf = o; r.last = 1'b0;
    tok_q.push_back(r);
  endfunction

  function automatic void put_text(logic [7:0] b);
    if (text_len < MaxTextBytes) begin
      put_rec(KIND_TEXT, b, 6'd0, 1'b0);
      text_len++;
    end else begin
      text_len = MaxTextBytes + 1;
    end
  endfunction

  function automatic void put_end(token_e t);
    put_rec(KIND_END, 8'd0, t, text_len > MaxTextBytes);
    text_len = 0;
    scan = M_IDLE;
  endfunction

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_dig(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_odig(logic [7:0] b);
    return b >= "0" && b <= "7";
  endfunction

  function automatic int hex_of(logic [7:0] b);
    if (is_dig(b)) return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic bit word_is(string w);
    if (text_len != w.len() || w.len() > KeywordStoreBytes) return 0;
    for (int i = 0; i < w.len(); i++) if (kw_store[i] != w[i]) return 0;
    return 1;
  endfunction

  function automatic void end_word();
    string kws[10];
    token_e t;
    kws = '{"if", "elif", "else", "while", "for", "in", "break", "continue",
            "return", "implement"};
    t = T_IDENT;
    foreach (kws[i]) if (word_is(kws[i])) t = T_KEYWORD;
    if (word_is("has")) t = T_HAS;
    else if (word_is("not")) t = T_NOT;
    else if (word_is("and")) t = T_AND;
    else if (word_is("or")) t = T_OR;
    put_end(t);
  endfunction

  function automatic void put_utf8(logic [31:0] c);
    if (c < 32'h80) begin
      put_text(c[7:0]);
    end else if (c < 32'h800) begin
      put_text(8'(32'hC0 | (c >> 6)));
      put_text(8'(32'h80 | (c & 32'h3F)));
    end else if (c < 32'h10000) begin
      put_text(8'(32'hE0 | (c >> 12)));
      put_text(8'(32'h80 | ((c >> 6) & 32'h3F)));
      put_text(8'(32'h80 | (c & 32'h3F)));
    end else begin
      put_text(8'(32'hF0 | (c >> 18)));
      put_text(8'(32'h80 | ((c >> 12) & 32'h3F)));
      put_text(8'(32'h80 | ((c >> 6) & 32'h3F)));
      put_text(8'(32'h80 | (c & 32'h3F)));
    end
  endfunction

  function automatic void one_byte(logic [7:0] b, token_e t);
    put_text(b);
    put_end(t);
  endfunction

  function automatic void open_tok(logic [7:0] b, mode_e m);
    put_text(b);
    scan = m;
  endfunction

  function automatic void start_tok(logic [7:0] b);
    case (b)
      " ", "\t": ;
      "#": scan = M_COMMENT;
      ";", "\n", 8'h0d: put_end(T_NEWLINE);
      "$": scan = M_PROP;
      "\"", "'": begin
        quote_single = (b == "'");
        scan = M_STR;
      end
      "0": open_tok(b, M_ZERO);
      "{": one_byte(b, T_LBRACE);
      "}": one_byte(b, T_RBRACE);
      "(": one_byte(b, T_LPAREN);
      ")": one_byte(b, T_RPAREN);
      "[": one_byte(b, T_LBRACKET);
      "]": one_byte(b, T_RBRACKET);
      "\\": one_byte(b, T_ATTR);
      ",": one_byte(b, T_COMMA);
      ":": one_byte(b, T_COLON);
      "+": one_byte(b, T_ADD);
      "/": one_byte(b, T_DIV);
      "%": one_byte(b, T_MOD);
      "=": open_tok(b, M_OP_EQ);
      "?": open_tok(b, M_OP_QUEST);
      "-": open_tok(b, M_OP_MINUS);
      "*": open_tok(b, M_OP_STAR);
      "<": open_tok(b, M_OP_LT);
      ">": open_tok(b, M_OP_GT);
      "!": open_tok(b, M_OP_BANG);
      default: begin
        if (is_alpha(b) || b == "_") begin
          kw_store[0] = b;
          open_tok(b, M_IDENT);
        end else if (is_dig(b)) begin
          open_tok(b, M_DEC);
        end else begin
          one_byte(b, T_UNDEF);
        end
      end
    endcase
  endfunction

  function automatic bit op_pair(logic [7:0] b, logic [7:0] want, token_e t2, token_e t1);
    if (b == want) begin
      one_byte(b, t2);
      return 1;
    end
    put_end(t1);
    return 0;
  endfunction

  function automatic void str_escape(logic [7:0] b);
    scan = M_STR;
    esc_val = 0;
    esc_cnt = 0;
    case (b)
      "n": put_text(8'h0a);
      "r": put_text(8'h0d);
      "t": put_text(8'h09);
      "v": put_text(8'h0b);
      "f": put_text(8'h0c);
      "a": put_text(8'h07);
      "x": scan = M_ESC_HEX;
      "u": scan = M_ESC_U4;
      "U": scan = M_ESC_U8;
      default: begin
        if (is_odig(b)) begin
          esc_val = 32'(b - "0");
          esc_cnt = 1;
          scan = M_ESC_OCT;
        end else begin
          put_text(b);
        end
      end
    endcase
  endfunction

  function automatic bit scan_byte(logic [7:0] b);
    int h;
    case (scan)
      M_COMMENT: begin
        if (b == "\n") begin
          scan = M_IDLE;
          return 0;
        end
        return 1;
      end
      M_IDENT: begin
        if (is_alpha(b) || is_dig(b) || b == "_") begin
          if (text_len < KeywordStoreBytes) kw_store[text_len] = b;
          put_text(b);
          return 1;
        end
        end_word();
        return 0;
      end
      M_PROP: begin
        if (is_alpha(b) || is_dig(b) || b == "_") begin
          put_text(b);
          return 1;
        end
        put_end(T_PROPERTY);
        return 0;
      end
      M_DEC, M_HEX, M_BIN, M_OCT: begin
        if ((scan == M_DEC && is_dig(b)) || (scan == M_HEX && hex_of(b) >= 0) ||
            (scan == M_BIN && (b == "0" || b == "1")) || (scan == M_OCT && is_odig(b))) begin
          put_text(b);
          return 1;
        end
        put_end(T_NUMBER);
        return 0;
      end
      M_ZERO: begin
        if (b == "x" || b == "X") open_tok("x", M_HEX);
        else if (b == "b" || b == "B") open_tok("b", M_BIN);
        else if (b == "o" || b == "O") open_tok("o", M_OCT);
        else if (is_odig(b)) open_tok(b, M_OCT);
        else begin
          put_end(T_NUMBER);
          return 0;
        end
        return 1;
      end
      M_STR: begin
        if (b == (quote_single ? 8'h27 : 8'h22)) put_end(T_STRING);
        else if (b == "\\") scan = M_STR_ESC;
        else put_text(b);
        return 1;
      end
      M_STR_ESC: begin
        str_escape(b);
        return 1;
      end
      M_ESC_OCT: begin
        if (is_odig(b)) begin
          esc_val = esc_val * 8 + 32'(b - "0");
          esc_cnt++;
          if (esc_cnt >= 3) begin
            put_text(esc_val[7:0]);
            scan = M_STR;
          end
          return 1;
        end
        put_text(esc_val[7:0]);
        scan = M_STR;
        return 0;
      end
      M_ESC_HEX: begin
        h = hex_of(b);
        if (h >= 0) begin
          esc_val = esc_val * 16 + 32'(h);
          return 1;
        end
        put_text(esc_val[7:0]);
        scan = M_STR;
        return 0;
      end
      M_ESC_U4, M_ESC_U8: begin
        h = hex_of(b);
        if (h >= 0) begin
          esc_val = esc_val * 16 + 32'(h);
          esc_cnt++;
          if (esc_cnt >= (scan == M_ESC_U4 ? 4 : 8)) begin
            put_utf8(esc_val);
            scan = M_STR;
          end
          return 1;
        end
        put_utf8(esc_val);
        scan = M_STR;
        return 0;
      end
      M_OP_EQ: begin
        if (b == ">") begin
          one_byte(b, T_BLOCK);
          return 1;
        end
        return op_pair(b, "=", T_EQ, T_ASSIGN);
      end
      M_OP_QUEST: return op_pair(b, "?", T_DQUEST, T_QUEST);
      M_OP_MINUS: return op_pair(b, ">", T_ARROW, T_MINUS);
      M_OP_STAR:  return op_pair(b, "*", T_POW, T_MUL);
      M_OP_LT:    return op_pair(b, "=", T_LE, T_LT);
      M_OP_GT:    return op_pair(b, "=", T_GE, T_GT);
      M_OP_BANG:  return op_pair(b, "=", T_NE, T_UNDEF);
      default: begin
        scan = M_IDLE;
        start_tok(b);
        return 1;
      end
    endcase
  endfunction

  function automatic void close_input();
    case (scan)
      M_IDENT: end_word();
      M_PROP: put_end(T_PROPERTY);
      M_DEC, M_ZERO, M_HEX, M_BIN, M_OCT: put_end(T_NUMBER);
      M_STR, M_STR_ESC, M_ESC_OCT, M_ESC_HEX, M_ESC_U4, M_ESC_U8: put_end(T_UNDEF);
      M_OP_EQ: put_end(T_ASSIGN);
      M_OP_QUEST: put_end(T_QUEST);
      M_OP_MINUS: put_end(T_MINUS);
      M_OP_STAR: put_end(T_MUL);
      M_OP_LT: put_end(T_LT);
      M_OP_GT: put_end(T_GT);
      M_OP_BANG: put_end(T_UNDEF);
      default: ;
    endcase
    text_len = 0;
    put_end(T_EOF);
    esc_val = 0;
    esc_cnt = 0;
  endfunction

  function automatic void predict_word(logic [7:0] b, logic eoi);
    int n0;
    n0 = tok_q.size();
    if (eoi || b == 8'd0) begin
      close_input();
    end else begin
      for (int i = 0; i < 4; i++) if (scan_byte(b)) break;
    end
    if (tok_q.size() > n0) tok_q[tok_q.size()-1].last = 1'b1;
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    fail_cnt_o++;
  endtask

  initial begin
    fail_cnt_o = 0;
    scan = M_IDLE;
    quote_single = 1'b0;
    esc_val = '0;
    esc_cnt = 0;
    text_len = 0;
  end

  always @(posedge clk_i) begin
    tok_rec_t e;
    if (rst_ni) begin
      if (src_i.valid && src_i.ready) predict_word(src_i.in_byte, src_i.end_of_input);
      if (rec_i.valid && rec_i.ready) begin
        if (tok_q.size() == 0) begin
          report("unexpected record kind", 8'(rec_i.record_kind), 8'hxx);
        end else begin
          e = tok_q.pop_front();
          if (rec_i.record_kind !== e.kind)
            report("record kind", 8'(rec_i.record_kind), 8'(e.kind));
          if (rec_i.text_byte !== e.text) report("text byte", rec_i.text_byte, e.text);
          if (rec_i.token_type !== e.ttype)
            report("token type", 8'(rec_i.token_type), 8'(e.ttype));
          if (rec_i.text_overflow !== e.ovf)
            report("text overflow", 8'(rec_i.text_overflow), 8'(e.ovf));
          if (rec_i.last !== e.last) report("last", 8'(rec_i.last), 8'(e.last));
        end
      end
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Script lexer tokenizer testbench
// Streams directed and random source text with random gaps on both channels
// and a long record hold-off; the checker predicts and compares the records.
// ----------------------------------------------------------------------------
module tb;
  import slt_pkg::*;

  localparam int CycleLimit = 600000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   fail_cnt;
  int   pending;
  int   sent = 0;

  slt_in_if  in_if ();
  slt_out_if out_if ();

  script_lexer_tokenizer u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  slt_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .src_i     (in_if),
    .rec_i     (out_if),
    .fail_cnt_o(fail_cnt),
    .pending_o (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int hold;
    int g;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (cycles == 300) hold = 400;
      if (hold > 0) begin
        hold--;
        out_if.ready = 1'b0;
      end else if (out_if.ready == 1'b0 || (cycles / 500) % 3 == 0) begin
        out_if.ready = 1'b1;
      end else begin
        g = gap_len();
        if (g > 0) begin
          out_if.ready = 1'b0;
          hold = g - 1;
        end
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic eoi);
    int g;
    g = ((cycles / 700) % 4 == 1) ? 0 : gap_len();
    if (g > 0) begin
      in_if.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.in_byte = b;
    in_if.end_of_input = eoi;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic send_rand_token();
    string kws[14];
    string hexd;
    string ops;
    int    n;
    kws = '{"if", "elif", "else", "while", "for", "in", "break", "continue",
            "return", "implement", "has", "not", "and", "or"};
    hexd = "0123456789abcdefABCDEFgz";
    ops = "{}()[]\\,:+/%=?-*<>!";
    case ($urandom_range(0, 11))
      0: send_text(kws[$urandom_range(0, 13)]);
      1: begin
        n = $urandom_range(1, 12);
        send_word(8'("a" + $urandom_range(0, 25)), 1'b0);
        repeat (n - 1)
          send_word($urandom_range(0, 2) == 0 ? "_" : 8'("a" + $urandom_range(0, 25)), 1'b0);
      end
      2: begin
        send_word("$", 1'b0);
        repeat ($urandom_range(0, 5)) send_word(8'("A" + $urandom_range(0, 25)), 1'b0);
      end
      3: begin
        send_word("0", 1'b0);
        case ($urandom_range(0, 4))
          0: send_word($urandom_range(0, 1) ? "x" : "X", 1'b0);
          1: send_word($urandom_range(0, 1) ? "b" : "B", 1'b0);
          2: send_word($urandom_range(0, 1) ? "o" : "O", 1'b0);
          default: ;
        endcase
        repeat ($urandom_range(0, 5)) send_word(hexd[$urandom_range(0, 23)], 1'b0);
      end
      4: repeat ($urandom_range(1, 6)) send_word(8'("0" + $urandom_range(0, 9)), 1'b0);
      5, 6: begin
        logic [7:0] q;
        logic [7:0] c;
        q = $urandom_range(0, 1) ? "'" : "\"";
        send_word(q, 1'b0);
        repeat ($urandom_range(0, 10)) begin
          if ($urandom_range(0, 2) == 0) begin
            send_word("\\", 1'b0);
            case ($urandom_range(0, 5))
              0: send_word("u", 1'b0);
              1: send_word("U", 1'b0);
              2: send_word("x", 1'b0);
              3: send_word(8'("0" + $urandom_range(0, 7)), 1'b0);
              default: send_word(8'($urandom_range(1, 255)), 1'b0);
            endcase
            repeat ($urandom_range(0, 9)) send_word(hexd[$urandom_range(0, 23)], 1'b0);
          end else begin
            c = 8'($urandom_range(1, 255));
            if (c != q && c != "\\") send_word(c, 1'b0);
          end
        end
        if ($urandom_range(0, 9) != 0) send_word(q, 1'b0);
      end
      7: send_text(ops.substr($urandom_range(0, 18), 18).substr(0, 1));
      8: send_word(" ", 1'b0);
      9: send_word($urandom_range(0, 2) == 0 ? 8'h0d : ($urandom_range(0, 1) ? "\n" : ";"),
                   1'b0);
      10: begin
        send_text("# ");
        repeat ($urandom_range(0, 6)) send_word(8'($urandom_range(1, 255)), 1'b0);
        send_word("\n", 1'b0);
      end
      default: begin
        if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)), 1'b1);
        else send_word(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    if ($urandom_range(0, 2) == 0) send_word(" ", 1'b0);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.in_byte = 8'd0;
    in_if.end_of_input = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    send_text("if elif else while for in break continue return implement ");
    send_text("has not and or iff implementx continues\t$prop_1 ");
    send_text("0x1F 0XaB 0b101 0B1 0o17 0O7 017 09 0 123 ");
    send_text("\"a\\n\\r\\t\\v\\f\\a\\\\\\'\\\"\\?\\q\\101\\7z\\x41g\\x\\u00e9\\u20AC");
    send_text("\\U0001F600\\U12345678\\uZ\" 'it\"s' ");
    send_text("{ } ( ) [ ] \\ , : + / % == => = ?? ? -> - ** * <= < >= > != ! ;");
    send_word(8'h0d, 1'b0);
    send_text("\n# comment ;\nx");
    send_word(8'h80, 1'b0);
    send_word(8'hff, 1'b0);
    send_word(8'h00, 1'b0);
    send_text("\"open");
    send_word(8'hff, 1'b1);
    send_text("'esc\\");
    send_word(8'h00, 1'b1);
    send_text("!");
    send_word(8'h00, 1'b1);
    while (sent < 400) send_rand_token();
    send_word(8'h00, 1'b1);
    in_if.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/slt_pkg.sv
sv/slt_if.sv
sv/slt_core.sv
sv/slt_obuf.sv
sv/script_lexer_tokenizer.sv
bench/slt_checker.sv
bench/tb.sv
